### rtl/core/bmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bracket match checker package
// Shared types, codes and helper functions of the bracket match checker.
// ----------------------------------------------------------------------------
package bmc_pkg;

    localparam int STACK_DEPTH   = 32;
    localparam int POS_BITS      = 16;
    localparam int OUT_POS_W     = 16;
    localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    // Input selector codes.
    localparam logic [1:0] FUNC_TEXT = 2'd0;
    localparam logic [1:0] FUNC_EOL  = 2'd1;
    localparam logic [1:0] FUNC_EOI  = 2'd2;

    // Result kinds.
    localparam logic [2:0] KIND_MISMATCH       = 3'd0;
    localparam logic [2:0] KIND_UNMATCHED_RIGHT = 3'd1;
    localparam logic [2:0] KIND_UNMATCHED_LEFT = 3'd2;
    localparam logic [2:0] KIND_OVERFLOW       = 3'd3;
    localparam logic [2:0] KIND_END            = 3'd4;

    // Commands from the front to the back.
    localparam logic [1:0] OP_LEFT  = 2'd0;
    localparam logic [1:0] OP_RIGHT = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // Bracket classes.
    localparam logic [1:0] BR_BRACE  = 2'd0;
    localparam logic [1:0] BR_PAREN  = 2'd1;
    localparam logic [1:0] BR_SQUARE = 2'd2;

    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic [7:0]           found_char;
        logic [OUT_POS_W-1:0] found_line;
        logic [OUT_POS_W-1:0] found_column;
        logic [7:0]           partner_char;
        logic [OUT_POS_W-1:0] partner_line;
        logic [OUT_POS_W-1:0] partner_column;
        logic                 last;
    } res_item_t;

    typedef struct packed {
        logic [1:0]          op;
        logic [1:0]          bkind;
        logic [7:0]          char_code;
        logic [POS_BITS-1:0] line;
        logic [POS_BITS-1:0] column;
    } cmd_t;

    typedef struct packed {
        logic [1:0]          bkind;
        logic [POS_BITS-1:0] line;
        logic [POS_BITS-1:0] column;
    } entry_t;

    function automatic logic is_left(input logic [7:0] ch);
        return ch inside {CH_LBRACE, CH_LPAREN, CH_LSQUARE};
    endfunction

    function automatic logic is_right(input logic [7:0] ch);
        return ch inside {CH_RBRACE, CH_RPAREN, CH_RSQUARE};
    endfunction

    function automatic logic [1:0] bracket_class(input logic [7:0] ch);
        logic [1:0] k;
        k = BR_BRACE;
        if (ch inside {CH_LPAREN, CH_RPAREN}) begin
            k = BR_PAREN;
        end
        else if (ch inside {CH_LSQUARE, CH_RSQUARE}) begin
            k = BR_SQUARE;
        end
        return k;
    endfunction

    function automatic logic [7:0] left_byte(input logic [1:0] k);
        logic [7:0] b;
        case (k)
            BR_PAREN:  b = CH_LPAREN;
            BR_SQUARE: b = CH_LSQUARE;
            default:   b = CH_LBRACE;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

### rtl/core/bmc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bracket match checker front end
// Accepts characters, keeps the line and column counters and forwards
// bracket and end-of-input commands to the command queue.
// ----------------------------------------------------------------------------
module bmc_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  bmc_pkg::in_item_t    item,
    output logic                 cmd_push,
    output bmc_pkg::cmd_t        cmd,
    input  wire logic            cmd_full
);
    import bmc_pkg::*;

    logic [POS_BITS-1:0] line_reg, line_next;
    logic [POS_BITS-1:0] col_reg, col_next;
    logic                accept;
    logic                left_ch, right_ch;

    assign full    = cmd_full;
    assign accept  = push && !cmd_full;
    assign left_ch  = is_left(item.char_code);
    assign right_ch = is_right(item.char_code);

    always_comb
    begin
        line_next     = line_reg;
        col_next      = col_reg;
        cmd_push      = 1'b0;
        cmd.op        = OP_END;
        cmd.bkind     = bracket_class(item.char_code);
        cmd.char_code = item.char_code;
        cmd.line      = line_reg;
        if (col_reg != POS_MAX) begin
            cmd.column = col_reg + POS_BITS'(1);
        end
        else begin
            cmd.column = col_reg;
        end
        if (accept) begin
            case (item.func)
                FUNC_TEXT:
                begin
                    col_next = cmd.column;
                    cmd_push = left_ch || right_ch;
                    cmd.op   = left_ch ? OP_LEFT : OP_RIGHT;
                end
                FUNC_EOL:
                begin
                    if (line_reg != POS_MAX) begin
                        line_next = line_reg + POS_BITS'(1);
                    end
                    col_next = '0;
                end
                FUNC_EOI:
                begin
                    cmd_push  = 1'b1;
                    cmd.op    = OP_END;
                    line_next = POS_BITS'(1);
                    col_next  = '0;
                end
                default:
                begin
                    cmd_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_reg <= POS_BITS'(1);
            col_reg  <= '0;
        end
        else begin
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

endmodule
`default_nettype wire

### rtl/core/bmc_cmd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bracket match checker command queue
// Two-entry queue that decouples the front end from the stack engine.
// ----------------------------------------------------------------------------
module bmc_cmd_queue (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  bmc_pkg::cmd_t   wr_cmd,
    output logic            full,
    output logic            valid,
    output bmc_pkg::cmd_t   rd_cmd,
    input  wire logic       rd_en
);
    import bmc_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr, do_rd;

    assign full   = (count_reg == 2'd2);
    assign valid  = (count_reg != 2'd0);
    assign rd_cmd = slot_reg[rd_ptr_reg];
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_wr && do_rd) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'd2)
        else $error("command queue count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !full && !(rd_en && valid)) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("command queue lost a write");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("command queue pointers disagree with count");

endmodule
`default_nettype wire

### rtl/core/bmc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bracket match checker stack engine
// Executes bracket commands against the bracket stack memory and drives
// the result register.
// ----------------------------------------------------------------------------
module bmc_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    input  bmc_pkg::cmd_t        cmd,
    output logic                 cmd_pop,
    output logic                 empty,
    input  wire logic            pop,
    output bmc_pkg::res_item_t   result
);
    import bmc_pkg::*;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_POP_CMP    = 3'd1;
    localparam logic [2:0] S_DRAIN_RD   = 3'd2;
    localparam logic [2:0] S_DRAIN_EMIT = 3'd3;
    localparam logic [2:0] S_END        = 3'd4;

    entry_t             stack_mem [STACK_DEPTH];
    entry_t             rd_data_reg;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    entry_t             wr_data;

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   count_dec;
    cmd_t               cur_reg, cur_next;
    logic               res_valid_reg;
    res_item_t          res_reg, res_next;
    logic               emit;
    logic               can_emit;

    assign can_emit  = !res_valid_reg || pop;
    assign count_dec = count_reg - CNT_W'(1);
    assign empty     = !res_valid_reg;
    assign result    = res_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        cmd_pop    = 1'b0;
        emit       = 1'b0;
        res_next   = '0;
        rd_en      = 1'b0;
        rd_addr    = count_dec[ADDR_W-1:0];
        wr_en      = 1'b0;
        wr_addr    = count_reg[ADDR_W-1:0];
        wr_data.bkind  = cmd.bkind;
        wr_data.line   = cmd.line;
        wr_data.column = cmd.column;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid) begin
                    case (cmd.op)
                        OP_LEFT:
                        begin
                            if (count_reg < CNT_W'(STACK_DEPTH)) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                cmd_pop    = 1'b1;
                            end
                            else if (can_emit) begin
                                emit                  = 1'b1;
                                res_next.kind         = KIND_OVERFLOW;
                                res_next.found_char   = cmd.char_code;
                                res_next.found_line   = OUT_POS_W'(cmd.line);
                                res_next.found_column = OUT_POS_W'(cmd.column);
                                res_next.last         = 1'b1;
                                cmd_pop               = 1'b1;
                            end
                        end
                        OP_RIGHT:
                        begin
                            if (count_reg == '0) begin
                                if (can_emit) begin
                                    emit                  = 1'b1;
                                    res_next.kind         = KIND_UNMATCHED_RIGHT;
                                    res_next.found_char   = cmd.char_code;
                                    res_next.found_line   = OUT_POS_W'(cmd.line);
                                    res_next.found_column = OUT_POS_W'(cmd.column);
                                    res_next.last         = 1'b1;
                                    cmd_pop               = 1'b1;
                                end
                            end
                            else begin
                                rd_en      = 1'b1;
                                count_next = count_dec;
                                cur_next   = cmd;
                                cmd_pop    = 1'b1;
                                state_next = S_POP_CMP;
                            end
                        end
                        OP_END:
                        begin
                            cmd_pop    = 1'b1;
                            state_next = S_DRAIN_RD;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_POP_CMP:
            begin
                if (rd_data_reg.bkind == cur_reg.bkind) begin
                    state_next = S_IDLE;
                end
                else if (can_emit) begin
                    emit                    = 1'b1;
                    res_next.kind           = KIND_MISMATCH;
                    res_next.found_char     = cur_reg.char_code;
                    res_next.found_line     = OUT_POS_W'(cur_reg.line);
                    res_next.found_column   = OUT_POS_W'(cur_reg.column);
                    res_next.partner_char   = left_byte(rd_data_reg.bkind);
                    res_next.partner_line   = OUT_POS_W'(rd_data_reg.line);
                    res_next.partner_column = OUT_POS_W'(rd_data_reg.column);
                    res_next.last           = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            S_DRAIN_RD:
            begin
                if (count_reg == '0) begin
                    state_next = S_END;
                end
                else begin
                    rd_en      = 1'b1;
                    count_next = count_dec;
                    state_next = S_DRAIN_EMIT;
                end
            end
            S_DRAIN_EMIT:
            begin
                if (can_emit) begin
                    emit                  = 1'b1;
                    res_next.kind         = KIND_UNMATCHED_LEFT;
                    res_next.found_char   = left_byte(rd_data_reg.bkind);
                    res_next.found_line   = OUT_POS_W'(rd_data_reg.line);
                    res_next.found_column = OUT_POS_W'(rd_data_reg.column);
                    state_next            = S_DRAIN_RD;
                end
            end
            S_END:
            begin
                if (can_emit) begin
                    emit          = 1'b1;
                    res_next.kind = KIND_END;
                    res_next.last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (emit) begin
                res_valid_reg <= 1'b1;
            end
            else if (pop) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit) begin
            res_reg <= res_next;
        end
    end

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.last == (res_reg.kind != KIND_UNMATCHED_LEFT)))
        else $error("last flag does not match result kind");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_END) |-> (count_reg == '0))
        else $error("end result with entries still on the stack");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN_EMIT) |-> ($past(rd_en) || $past(state_reg) == S_DRAIN_EMIT))
        else $error("drain result without a stack read");

endmodule
`default_nettype wire

### rtl/core/bracket_match_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bracket match checker
// Checks bracket balance over a character stream and reports each problem.
// ----------------------------------------------------------------------------
// Characters, end-of-line and end-of-input marks enter through a queue-style
// port (push/full) and results leave through another (empty/pop). The front
// end takes one item per cycle while the command queue is not full and keeps
// line and column counters; bracket and end-of-input commands go through a
// two-entry command queue to the stack engine, which holds up to 32 open
// brackets in a memory with one write port and one registered read port. A
// left bracket is pushed directly, and a right bracket goes through a memory
// read and then a compare, during which the engine takes no new command. End
// of input takes the command, then reads and reports each leftover bracket,
// finds the stack empty and emits the end result, which is the only result
// with last set apart from single-result reports. The result register holds
// one result until it is popped.
module bracket_match_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  bmc_pkg::in_item_t    item,
    output logic                 empty,
    input  wire logic            pop,
    output bmc_pkg::res_item_t   result
);
    import bmc_pkg::*;

    logic   cmd_push;
    cmd_t   cmd_in;
    logic   cmd_full;
    logic   cmd_valid;
    cmd_t   cmd_out;
    logic   cmd_pop;

    bmc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cmd_push (cmd_push),
        .cmd      (cmd_in),
        .cmd_full (cmd_full)
    );

    bmc_cmd_queue u_cmd_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_cmd (cmd_in),
        .full   (cmd_full),
        .valid  (cmd_valid),
        .rd_cmd (cmd_out),
        .rd_en  (cmd_pop)
    );

    bmc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
`default_nettype wire

### tb/bracket_report_checker.sv
// ----------------------------------------------------------------------------
// Bracket report checker
// Watches both queue ports of the bracket match checker, predicts the reports
// that each accepted request causes and compares every popped report with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module bracket_report_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  bmc_pkg::in_item_t  item,
    input  logic               empty,
    input  logic               pop,
    input  bmc_pkg::res_item_t result,
    output int                 fail_count,
    output int                 pending_reports,
    output int                 reports_checked,
    output logic [4:0]         kinds_seen
);
    import bmc_pkg::*;

    entry_t              open_brackets [STACK_DEPTH];
    int                  open_depth;
    logic [POS_BITS-1:0] line_now;
    logic [POS_BITS-1:0] column_now;
    res_item_t           expected_reports [$];

    int                  fail_tally;
    int                  checked_tally;
    logic [4:0]          kinds_tally;
    res_item_t           want;
    bit                  bad;

    function automatic int opener_class(input logic [7:0] ch);
        case (ch)
            CH_LBRACE:  return BR_BRACE;
            CH_LPAREN:  return BR_PAREN;
            CH_LSQUARE: return BR_SQUARE;
            default:    return -1;
        endcase
    endfunction

    function automatic int closer_class(input logic [7:0] ch);
        case (ch)
            CH_RBRACE:  return BR_BRACE;
            CH_RPAREN:  return BR_PAREN;
            CH_RSQUARE: return BR_SQUARE;
            default:    return -1;
        endcase
    endfunction

    function automatic logic [7:0] opener_byte(input logic [1:0] k);
        case (k)
            BR_PAREN:  return CH_LPAREN;
            BR_SQUARE: return CH_LSQUARE;
            default:   return CH_LBRACE;
        endcase
    endfunction

    function automatic bit field_differs(input string name, input logic [15:0] exp_v,
                                         input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: report %0d field %s expected %0h actual %0h",
                     $time, checked_tally, name, exp_v, act_v);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_reports(input in_item_t req);
        res_item_t batch [$];
        res_item_t r;
        entry_t    e;
        int        lk;
        int        rk;
        lk = opener_class(req.char_code);
        rk = closer_class(req.char_code);
        case (req.func)
            FUNC_TEXT:
            begin
                if (column_now != POS_MAX) column_now++;
                if (lk >= 0) begin
                    if (open_depth < STACK_DEPTH) begin
                        e.bkind  = lk[1:0];
                        e.line   = line_now;
                        e.column = column_now;
                        open_brackets[open_depth] = e;
                        open_depth++;
                    end
                    else begin
                        // The bracket is dropped; only the report remains.
                        r = '0;
                        r.kind         = KIND_OVERFLOW;
                        r.found_char   = req.char_code;
                        r.found_line   = line_now[OUT_POS_W-1:0];
                        r.found_column = column_now[OUT_POS_W-1:0];
                        batch.push_back(r);
                    end
                end
                else if (rk >= 0) begin
                    if (open_depth == 0) begin
                        r = '0;
                        r.kind         = KIND_UNMATCHED_RIGHT;
                        r.found_char   = req.char_code;
                        r.found_line   = line_now[OUT_POS_W-1:0];
                        r.found_column = column_now[OUT_POS_W-1:0];
                        batch.push_back(r);
                    end
                    else begin
                        open_depth--;
                        e = open_brackets[open_depth];
                        if (int'(e.bkind) != rk) begin
                            r = '0;
                            r.kind           = KIND_MISMATCH;
                            r.found_char     = req.char_code;
                            r.found_line     = line_now[OUT_POS_W-1:0];
                            r.found_column   = column_now[OUT_POS_W-1:0];
                            r.partner_char   = opener_byte(e.bkind);
                            r.partner_line   = e.line[OUT_POS_W-1:0];
                            r.partner_column = e.column[OUT_POS_W-1:0];
                            batch.push_back(r);
                        end
                    end
                end
            end
            FUNC_EOL:
            begin
                if (line_now != POS_MAX) line_now++;
                column_now = '0;
            end
            FUNC_EOI:
            begin
                while (open_depth > 0) begin
                    open_depth--;
                    e = open_brackets[open_depth];
                    r = '0;
                    r.kind         = KIND_UNMATCHED_LEFT;
                    r.found_char   = opener_byte(e.bkind);
                    r.found_line   = e.line[OUT_POS_W-1:0];
                    r.found_column = e.column[OUT_POS_W-1:0];
                    batch.push_back(r);
                end
                r = '0;
                r.kind = KIND_END;
                batch.push_back(r);
                line_now   = 1;
                column_now = '0;
            end
            default:
            begin
            end
        endcase
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        foreach (batch[i]) expected_reports.push_back(batch[i]);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            open_depth    = 0;
            line_now      = 1;
            column_now    = '0;
            fail_tally    = 0;
            checked_tally = 0;
            kinds_tally   = '0;
            expected_reports.delete();
            fail_count      <= 0;
            pending_reports <= 0;
            reports_checked <= 0;
            kinds_seen      <= '0;
        end
        else begin
            if (pop && !empty) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: report with no expectation: expected none actual %h",
                             $time, result);
                    fail_tally++;
                end
                else begin
                    want = expected_reports.pop_front();
                    bad  = 1'b0;
                    bad |= field_differs("kind", 16'(want.kind), 16'(result.kind));
                    bad |= field_differs("found_char", 16'(want.found_char),
                                         16'(result.found_char));
                    bad |= field_differs("found_line", want.found_line, result.found_line);
                    bad |= field_differs("found_column", want.found_column,
                                         result.found_column);
                    bad |= field_differs("partner_char", 16'(want.partner_char),
                                         16'(result.partner_char));
                    bad |= field_differs("partner_line", want.partner_line,
                                         result.partner_line);
                    bad |= field_differs("partner_column", want.partner_column,
                                         result.partner_column);
                    bad |= field_differs("last", 16'(want.last), 16'(result.last));
                    if (bad) fail_tally++;
                    if (want.kind <= KIND_END) kinds_tally[want.kind] = 1'b1;
                end
                checked_tally++;
            end
            // A request accepted at this edge can only show up at a later one.
            if (push && !full) predict_reports(item);
            fail_count      <= fail_tally;
            pending_reports <= expected_reports.size();
            reports_checked <= checked_tally;
            kinds_seen      <= kinds_tally;
        end
    end

endmodule

### tb/bracket_match_checker_tb.sv
// ----------------------------------------------------------------------------
// Bracket match checker testbench
// Feeds directed and random bracket texts through the queue ports with random
// gaps on both sides and a long receiver hold-off; a separate checker
// predicts and compares every report.
// ----------------------------------------------------------------------------
module bracket_match_checker_tb;
    import bmc_pkg::*;

    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         IDLE_LIMIT   = 4000;
    localparam int         DRAIN_CYCLES = 64;
    localparam int         RANDOM_ITEMS = 190;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  item;
    logic      empty;
    logic      pop;
    res_item_t result;

    int         fail_count;
    int         pending_reports;
    int         reports_checked;
    logic [4:0] kinds_seen;

    bit         tx_on;
    bit         tx_burst;
    bit         rx_on;
    bit         rx_burst;
    bit         hold_req;
    int         items_sent;
    int         texts_sent;
    int         full_stalls;
    int         holds_done;
    int         gen_open [$];

    bracket_match_checker u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    bracket_report_checker u_report_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .item            (item),
        .empty           (empty),
        .pop             (pop),
        .result          (result),
        .fail_count      (fail_count),
        .pending_reports (pending_reports),
        .reports_checked (reports_checked),
        .kinds_seen      (kinds_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 48);
    endfunction

    function automatic logic [7:0] open_byte(input int k);
        case (k)
            1:       return CH_LPAREN;
            2:       return CH_LSQUARE;
            default: return CH_LBRACE;
        endcase
    endfunction

    function automatic logic [7:0] close_byte(input int k);
        case (k)
            1:       return CH_RPAREN;
            2:       return CH_RSQUARE;
            default: return CH_RBRACE;
        endcase
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b inside {CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_LSQUARE, CH_RSQUARE});
        return b;
    endfunction

    task automatic send_item(input logic [1:0] f, input logic [7:0] ch);
        in_item_t nxt;
        int       g;
        nxt.func      = f;
        nxt.char_code = ch;
        item <= nxt;
        if (!tx_on) push <= 1'b1;
        tx_on = 1'b1;
        do
            @(posedge clk);
        while (full);
        if (f != FUNC_UNUSED) items_sent++;
        g = tx_burst ? 0 : pick_gap();
        if (g > 0) begin
            push <= 1'b0;
            tx_on = 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_item(FUNC_TEXT, ch);
    endtask

    task automatic stop_sending();
        if (tx_on) begin
            push <= 1'b0;
            tx_on = 1'b0;
        end
    endtask

    // The report count from the checker is registered and trails the request.
    task automatic wait_drained();
        stop_sending();
        @(posedge clk);
        while (pending_reports != 0) @(posedge clk);
    endtask

    task automatic random_text();
        int len;
        int r;
        int k;
        logic [1:0] f;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(3, 25);
        gen_open.delete();
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, 2);
            if (r < 32) begin
                gen_open.push_back(k);
                send_char(open_byte(k));
            end
            else if (r < 57) begin
                if (gen_open.size() > 0) send_char(close_byte(gen_open.pop_back()));
                else send_char(close_byte(k));
            end
            else if (r < 63) begin
                if (gen_open.size() > 0) void'(gen_open.pop_back());
                send_char(close_byte(k));
            end
            else if (r < 84) begin
                send_char(8'($urandom_range(0, 255)));
            end
            else if (r < 92) begin
                send_item(FUNC_EOL, 8'($urandom));
            end
            else if (r < 96) begin
                send_item(FUNC_UNUSED, 8'($urandom));
            end
            else begin
                f = 2'($urandom_range(0, 3));
                if (f == FUNC_EOI) gen_open.delete();
                send_item(f, 8'($urandom));
            end
        end
        // Most texts close properly so that the stack unwinds to the bottom.
        if ($urandom_range(0, 9) < 7) begin
            while (gen_open.size() > 0) send_char(close_byte(gen_open.pop_back()));
        end
        send_item(FUNC_EOI, 8'($urandom));
        texts_sent++;
    endtask

    // Opens more brackets than the stack holds, then closes a few of them.
    task automatic deep_text();
        int n;
        n = $urandom_range(33, 40);
        for (int i = 0; i < n; i++) begin
            send_char(open_byte($urandom_range(0, 2)));
            if ($urandom_range(0, 7) == 0) send_char(plain_byte());
            if ($urandom_range(0, 15) == 0) send_item(FUNC_EOL, 8'($urandom));
        end
        repeat ($urandom_range(0, 4)) send_char(close_byte($urandom_range(0, 2)));
        send_item(FUNC_EOI, 8'($urandom));
        texts_sent++;
    endtask

    // Receiver side: pops with random gaps and one long hold-off on request.
    initial
    begin
        int g;
        pop      = 1'b0;
        rx_on    = 1'b0;
        rx_burst = 1'b0;
        wait (rst_n == 1'b1);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                if (rx_on) begin
                    pop <= 1'b0;
                    rx_on = 1'b0;
                end
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else begin
                g = rx_burst ? 0 : pick_gap();
                if (g > 0) begin
                    if (rx_on) begin
                        pop <= 1'b0;
                        rx_on = 1'b0;
                    end
                    repeat (g) @(posedge clk);
                end
            end
            if (!rx_on) begin
                pop <= 1'b1;
                rx_on = 1'b1;
            end
            do
                @(posedge clk);
            while (empty);
            if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
        end
    end

    // Watchdog: ends the run when neither port moves for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n == 1'b1);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if (push && full) full_stalls++;
            if ((push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("%0t: no request moved for %0d cycles, %0d reports still expected",
                 $time, IDLE_LIMIT, pending_reports);
        $display("bracket_match_checker test failed");
        $finish;
    end

    initial
    begin
        int random_start;
        int t;
        rst_n    = 1'b0;
        push     = 1'b0;
        item     = '0;
        tx_on    = 1'b0;
        tx_burst = 1'b0;
        hold_req = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: balanced nesting, a mismatch, an unmatched right bracket,
        // byte extremes, the unused selector, leftovers at end of input and
        // an end of input with nothing open.
        send_char(CH_LBRACE);
        send_char(CH_LPAREN);
        send_char(CH_LSQUARE);
        send_char(CH_RSQUARE);
        send_char(CH_RPAREN);
        send_char(CH_RBRACE);
        send_char(CH_LPAREN);
        send_char(CH_RSQUARE);
        send_char(CH_RBRACE);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h7C);
        send_item(FUNC_UNUSED, CH_LBRACE);
        send_item(FUNC_EOL, 8'hFF);
        send_char(CH_LSQUARE);
        send_char(CH_LBRACE);
        send_item(FUNC_EOI, 8'h00);
        send_item(FUNC_EOI, 8'hFF);
        wait_drained();

        random_start = items_sent;
        t = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if (t == 2) begin
                deep_text();
            end
            else if (t == 4) begin
                // Keep offering reports while the receiver holds off.
                hold_req = 1'b1;
                tx_burst = 1'b1;
                repeat (24) send_char(close_byte($urandom_range(0, 2)));
                send_item(FUNC_EOI, 8'($urandom));
                tx_burst = 1'b0;
                texts_sent++;
            end
            else if (t == 7) begin
                random_text();
                wait_drained();
            end
            else if ($urandom_range(0, 19) == 0) begin
                deep_text();
            end
            else begin
                random_text();
            end
            if ($urandom_range(0, 3) == 0) tx_burst = !tx_burst;
            t++;
        end
        tx_burst = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests in %0d texts; checked %0d reports, kinds seen %b.",
                 items_sent, texts_sent, reports_checked, kinds_seen);
        $display("Input held off by full for %0d cycles over %0d long receiver stalls.",
                 full_stalls, holds_done);
        if (fail_count == 0 && pending_reports == 0) begin
            $display("bracket_match_checker test passed");
        end
        else begin
            $display("bracket_match_checker test failed");
        end
        $finish;
    end

endmodule
